/* design/id3_pkg.sv */
// Package for the ID3v2 tag frame extractor: payload structs, parse phase codes,
// the front-to-back queue entry type and frame identifiers. No dependencies.
`default_nettype none
package id3_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic       out_kind;
    logic [1:0] field_code;
    logic       is_unicode;
    logic [7:0] out_byte;
    logic       field_last;
  } out_item_t;

  // entry handed from the parser to the emitter
  typedef struct packed {
    logic       flush;     // emit held header bytes first
    logic [3:0] flush_cnt; // number of held bytes to emit
    logic       emit;      // emit item below after the flush
    out_item_t  item;
  } job_t;

  localparam int unsigned QueueDepth = 4;

  localparam logic [3:0] PH_HEADER     = 4'd0;
  localparam logic [3:0] PH_PASS       = 4'd1;
  localparam logic [3:0] PH_EXT_SIZE   = 4'd2;
  localparam logic [3:0] PH_EXT_SKIP   = 4'd3;
  localparam logic [3:0] PH_FRAME_ID   = 4'd4;
  localparam logic [3:0] PH_PADDING    = 4'd5;
  localparam logic [3:0] PH_FRAME_SIZE = 4'd6;
  localparam logic [3:0] PH_FLAG1      = 4'd7;
  localparam logic [3:0] PH_FLAG2      = 4'd8;
  localparam logic [3:0] PH_SKIP       = 4'd9;
  localparam logic [3:0] PH_ENC        = 4'd10;
  localparam logic [3:0] PH_CONTENT    = 4'd11;

  localparam logic [31:0] ID_TALB = 32'h54414C42;
  localparam logic [31:0] ID_TIT2 = 32'h54495432;
  localparam logic [31:0] ID_TPE1 = 32'h54504531;
  localparam logic [31:0] ID_TYER = 32'h54594552;

endpackage
`default_nettype wire

/* design/id3_parser.sv */
// Front part: accepts raw bytes, tracks the tag parse and pushes one job per byte.
// Depends on id3_pkg; header bytes are kept here and read by the emitter.
`default_nettype none
module id3_parser
  import id3_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        take,
  input  wire in_item_t    in_data,
  output job_t             job,
  output logic             job_valid,
  output logic [8:0][7:0]  hold
);

  logic [8:0][7:0] hold_r;
  logic [3:0]      cnt_r, cnt_nxt;
  logic [3:0]      ph_r, ph_nxt;
  logic [27:0]     tag_r, tag_nxt;
  logic [31:0]     fld_r, fld_nxt;
  logic [31:0]     asm_r, asm_nxt;
  logic [31:0]     fid_r, fid_nxt;
  logic            uns_r, uns_nxt, uni_r, uni_nxt, pff_r, pff_nxt;
  logic [2:0]      cur_r, cur_nxt;
  logic [7:0]      b;
  logic            eos, deliver, bad;
  logic [31:0]     fld_dec;
  logic [3:0]      cnt_inc;

  assign b = in_data.in_byte;
  assign eos = in_data.end_of_stream;
  assign hold = hold_r;
  assign job_valid = take;
  assign fld_dec = fld_r - 32'd1;
  assign cnt_inc = cnt_r + 4'd1;
  assign bad = hold_r[0] != 8'h49 || hold_r[1] != 8'h44 || hold_r[2] != 8'h33 ||
               hold_r[3] > 8'h04 || hold_r[4] != 8'h00;

  always_comb begin
    cnt_nxt = cnt_r; ph_nxt = ph_r; tag_nxt = tag_r; fld_nxt = fld_r;
    asm_nxt = asm_r; fid_nxt = fid_r; uns_nxt = uns_r; uni_nxt = uni_r;
    pff_nxt = pff_r; cur_nxt = cur_r; deliver = 1'b1;
    job = '0;
    job.item.out_byte = b;
    unique case (ph_r)
      PH_HEADER: begin
        if (cnt_r < 4'd9) begin
          if (eos) begin
            job.flush = 1'b1; job.flush_cnt = cnt_r; job.emit = 1'b1;
          end else begin
            cnt_nxt = cnt_inc;
          end
        end else begin
          cnt_nxt = 4'd0;
          if (bad) begin
            job.flush = 1'b1; job.flush_cnt = 4'd9; job.emit = 1'b1;
            ph_nxt = PH_PASS;
          end else begin
            uns_nxt = hold_r[5][7]; uni_nxt = 1'b0; pff_nxt = 1'b0;
            tag_nxt = {hold_r[6][6:0], hold_r[7][6:0], hold_r[8][6:0], b[6:0]};
            asm_nxt = '0; fid_nxt = '0;
            ph_nxt = hold_r[5][6] ? PH_EXT_SIZE : PH_FRAME_ID;
            if (tag_nxt == 28'd0) ph_nxt = PH_PASS;
          end
        end
      end
      PH_PASS: job.emit = 1'b1;
      default: begin
        tag_nxt = tag_r - 28'd1;
        if (pff_r) begin
          pff_nxt = 1'b0;
          if (b == 8'h00) deliver = 1'b0;
        end else if (uns_r && b == 8'hff) begin
          pff_nxt = 1'b1;
        end
        if (deliver) begin
          case (ph_r)
            PH_EXT_SIZE, PH_FRAME_SIZE: begin
              asm_nxt = {asm_r[23:0], b};
              cnt_nxt = cnt_inc;
              if (cnt_inc >= 4'd4) begin
                cnt_nxt = 4'd0;
                fld_nxt = asm_nxt;
                if (ph_r == PH_FRAME_SIZE) ph_nxt = PH_FLAG1;
                else ph_nxt = (asm_nxt != 0) ? PH_EXT_SKIP : PH_FRAME_ID;
              end
            end
            PH_EXT_SKIP, PH_SKIP: begin
              fld_nxt = fld_dec;
              if (fld_dec == 0) ph_nxt = PH_FRAME_ID;
            end
            PH_FRAME_ID: begin
              fid_nxt = {fid_r[23:0], b};
              cnt_nxt = cnt_inc;
              if (cnt_inc >= 4'd4) begin
                cnt_nxt = 4'd0; asm_nxt = '0;
                ph_nxt = (fid_nxt != 0) ? PH_FRAME_SIZE : PH_PADDING;
              end
            end
            PH_FLAG1: ph_nxt = PH_FLAG2;
            PH_FLAG2: begin
              cur_nxt = 3'd0;
              if (!b[7]) begin
                if (fid_r == ID_TALB) cur_nxt = 3'd1;
                else if (fid_r == ID_TIT2) cur_nxt = 3'd2;
                else if (fid_r == ID_TPE1) cur_nxt = 3'd3;
                else if (fid_r == ID_TYER) cur_nxt = 3'd4;
              end
              if (cur_nxt != 0 && fld_r != 0) ph_nxt = PH_ENC;
              else begin
                ph_nxt = (fld_r != 0) ? PH_SKIP : PH_FRAME_ID;
                cur_nxt = 3'd0;
              end
            end
            PH_ENC: begin
              fld_nxt = fld_dec;
              uni_nxt = (b == 8'd1);
              if (fld_dec == 0) begin
                ph_nxt = PH_FRAME_ID; cur_nxt = 3'd0;
              end else ph_nxt = PH_CONTENT;
            end
            PH_CONTENT: begin
              fld_nxt = fld_dec;
              job.emit = 1'b1;
              job.item.out_kind = 1'b1;
              job.item.field_code = 2'(cur_r - 3'd1);
              job.item.is_unicode = uni_r;
              job.item.field_last = (fld_dec == 0);
              if (fld_dec == 0) begin
                ph_nxt = PH_FRAME_ID; cur_nxt = 3'd0;
              end
            end
            default: ; // padding: discard
          endcase
        end
        if (tag_nxt == 28'd0) begin
          ph_nxt = PH_PASS; uns_nxt = 1'b0; uni_nxt = 1'b0; pff_nxt = 1'b0;
          cur_nxt = 3'd0; cnt_nxt = 4'd0;
        end
      end
    endcase
    if (eos) begin
      cnt_nxt = '0; ph_nxt = PH_HEADER; tag_nxt = '0; fld_nxt = '0; asm_nxt = '0;
      fid_nxt = '0; uns_nxt = 1'b0; uni_nxt = 1'b0; pff_nxt = 1'b0; cur_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && ph_r == PH_HEADER && cnt_r < 4'd9 && !eos) hold_r[cnt_r] <= b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; ph_r <= PH_HEADER; tag_r <= '0; fld_r <= '0; asm_r <= '0;
      fid_r <= '0; uns_r <= 1'b0; uni_r <= 1'b0; pff_r <= 1'b0; cur_r <= '0;
    end else if (take) begin
      cnt_r <= cnt_nxt; ph_r <= ph_nxt; tag_r <= tag_nxt; fld_r <= fld_nxt;
      asm_r <= asm_nxt; fid_r <= fid_nxt; uns_r <= uns_nxt; uni_r <= uni_nxt;
      pff_r <= pff_nxt; cur_r <= cur_nxt;
    end
  end

endmodule
`default_nettype wire

/* design/id3_emitter.sv */
// Back part: job queue plus emitter that expands flush jobs into held bytes.
// Depends on id3_pkg; header bytes come from the parser.
`default_nettype none
module id3_emitter
  import id3_pkg::*;
#(
  parameter int unsigned DEPTH = QueueDepth
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            job_valid,
  input  wire job_t            job,
  input  wire logic [8:0][7:0] hold,
  output logic                 q_full,
  output logic                 out_empty,
  input  wire logic            out_pop,
  output out_item_t            out_data
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  job_t            mem_r [DEPTH];
  logic [AW-1:0]   wp_r, rp_r;
  logic [AW:0]     cnt_r;
  logic [3:0]      idx_r;   // position inside the current job's flush
  logic            flush_pend_r; // a job that reads held bytes is still queued
  logic            head_v, last_part, adv, push;
  job_t            head;

  assign head = mem_r[rp_r];
  assign head_v = cnt_r != 0;
  assign push = job_valid && (job.emit || job.flush);
  // hold input while held bytes are still to be sent, so a new stream cannot
  // overwrite the header hold under a queued flush
  assign q_full = (cnt_r >= (AW+1)'(DEPTH - 1)) || flush_pend_r;
  assign last_part = !(head.flush && idx_r < head.flush_cnt);
  assign out_empty = !head_v || (last_part && !head.emit);

  always_comb begin
    out_data = head.item;
    if (!last_part) begin
      out_data = '0;
      out_data.out_byte = hold[idx_r];
    end
  end

  // a job with nothing to emit retires at once
  assign adv = head_v && last_part && (!head.emit || out_pop);

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0; idx_r <= '0; flush_pend_r <= 1'b0;
    end else begin
      if (push)
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (adv) begin
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
        idx_r <= '0;
      end else if (head_v && !last_part && out_pop) begin
        idx_r <= idx_r + 4'd1;
      end
      if (push && job.flush && job.flush_cnt != 4'd0)
        flush_pend_r <= 1'b1;
      else if (adv && head.flush && head.flush_cnt != 4'd0)
        flush_pend_r <= 1'b0;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(adv);
    end
  end

endmodule
`default_nettype wire

/* design/id3v2_tag_frame_extractor_top.sv */
// Top level of the ID3v2 tag frame extractor.
// Instantiates id3_parser (front) and id3_emitter (back); types from id3_pkg.
//
// Usage: push file bytes on in_data with in_push while in_full is low; an
// end_of_stream byte ends a stream and the next byte starts a fresh one.
// Results appear on out_data while out_empty is low and are taken with out_pop.
// Audio bytes carry out_kind 0; metadata content bytes of album, title,
// performer and year frames carry out_kind 1, the field code, the unicode flag
// and a last marker.
// Each accepted byte's job is registered in the emitter queue before it shows.
// Throughput: one byte per cycle while at most one result per byte is made.
// A non-ID3 header (or a flush at end of stream) releases up to ten results
// from one byte; the emitter sends those one per cycle and input is held off
// until the held header bytes have all been sent, set by the single result port.
// Reset: synchronous, active low; clears parse state and the queue.
// When the receiver stalls the queue fills (QUEUE_DEPTH-1 transactions) and
// in_full rises.
`default_nettype none
module id3v2_tag_frame_extractor_top
  import id3_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_push,
  output logic           in_full,
  input  wire in_item_t  in_data,
  output logic           out_empty,
  input  wire logic      out_pop,
  output out_item_t      out_data
);

  job_t            job;
  logic            job_valid, take;
  logic [8:0][7:0] hold;

  assign take = in_push && !in_full;

  id3_parser u_parser (
    .clk, .rst_n, .take, .in_data, .job, .job_valid, .hold
  );

  id3_emitter #(.DEPTH(QUEUE_DEPTH)) u_emitter (
    .clk, .rst_n, .job_valid, .job, .hold,
    .q_full(in_full), .out_empty, .out_pop, .out_data
  );

endmodule
`default_nettype wire

/* verif/id3v2_tag_frame_extractor_top_tb.sv */
// Testbench for id3v2_tag_frame_extractor_top: drives byte streams through the
// push/full port, predicts every result and checks the pop/empty side. Uses id3_pkg.
module id3v2_tag_frame_extractor_top_tb;
  import id3_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_push;
  logic      in_full;
  in_item_t  in_data;
  logic      out_empty;
  logic      out_pop;
  out_item_t out_data;

  id3v2_tag_frame_extractor_top u_dut (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full), .in_data(in_data),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data)
  );

  localparam logic [2:0] FL_UNSYNC = 3'd1;
  localparam logic [2:0] FL_UNICODE = 3'd2;
  localparam logic [2:0] FL_PENDFF = 3'd4;
  localparam logic [2:0] FLD_NONE = 3'd0;
  localparam logic [2:0] FLD_ALBUM = 3'd1;
  localparam logic [2:0] FLD_TITLE = 3'd2;
  localparam logic [2:0] FLD_PERFORMER = 3'd3;
  localparam logic [2:0] FLD_YEAR = 3'd4;

  // parser model state
  logic [7:0]  hold_buf [9];
  logic [3:0]  hold_cnt;
  logic [3:0]  phase;
  logic [27:0] tag_left;
  logic [31:0] frame_left;
  logic [31:0] size_word;
  logic [31:0] frame_id;
  logic [2:0]  flags;
  logic [2:0]  field_sel;

  out_item_t   expected_q[$];
  in_item_t    byte_q[$];
  int          errors = 0;
  int          send_idle = 0;
  int          recv_stall = 0;

  task automatic clear_parser();
    hold_cnt = 0; phase = PH_HEADER; tag_left = 0; frame_left = 0;
    size_word = 0; frame_id = 0; flags = 0; field_sel = FLD_NONE;
  endtask

  task automatic push_result(logic kind, logic [1:0] code, logic uni, logic [7:0] b,
                             logic last);
    out_item_t r;
    r.out_kind = kind; r.field_code = code; r.is_unicode = uni;
    r.out_byte = b; r.field_last = last;
    expected_q.push_back(r);
  endtask

  task automatic parse_tag_byte(logic [7:0] b);
    case (phase)
      PH_EXT_SIZE, PH_FRAME_SIZE: begin
        size_word = {size_word[23:0], b};
        hold_cnt = hold_cnt + 4'd1;
        if (hold_cnt >= 4) begin
          hold_cnt = 0;
          frame_left = size_word;
          if (phase == PH_FRAME_SIZE) phase = PH_FLAG1;
          else phase = (frame_left != 0) ? PH_EXT_SKIP : PH_FRAME_ID;
        end
      end
      PH_EXT_SKIP, PH_SKIP: begin
        frame_left--;
        if (frame_left == 0) phase = PH_FRAME_ID;
      end
      PH_FRAME_ID: begin
        frame_id = {frame_id[23:0], b};
        hold_cnt = hold_cnt + 4'd1;
        if (hold_cnt >= 4) begin
          hold_cnt = 0;
          size_word = 0;
          phase = (frame_id != 0) ? PH_FRAME_SIZE : PH_PADDING;
        end
      end
      PH_FLAG1: phase = PH_FLAG2;
      PH_FLAG2: begin
        field_sel = FLD_NONE;
        if (!b[7]) begin
          if (frame_id == ID_TALB) field_sel = FLD_ALBUM;
          else if (frame_id == ID_TIT2) field_sel = FLD_TITLE;
          else if (frame_id == ID_TPE1) field_sel = FLD_PERFORMER;
          else if (frame_id == ID_TYER) field_sel = FLD_YEAR;
        end
        if (field_sel != FLD_NONE && frame_left != 0) phase = PH_ENC;
        else begin
          phase = (frame_left != 0) ? PH_SKIP : PH_FRAME_ID;
          field_sel = FLD_NONE;
        end
      end
      PH_ENC: begin
        frame_left--;
        if (b == 8'd1) flags = flags | FL_UNICODE;
        else flags = flags & ~FL_UNICODE;
        if (frame_left == 0) begin
          phase = PH_FRAME_ID; field_sel = FLD_NONE;
        end else phase = PH_CONTENT;
      end
      PH_CONTENT: begin
        frame_left--;
        push_result(1'b1, 2'(field_sel - 3'd1), (flags & FL_UNICODE) != 0, b,
                    frame_left == 0);
        if (frame_left == 0) begin
          phase = PH_FRAME_ID; field_sel = FLD_NONE;
        end
      end
      default: ;
    endcase
  endtask

  task automatic predict_byte(in_item_t it);
    logic deliver;
    if (phase == PH_HEADER) begin
      if (hold_cnt < 9) begin
        if (it.end_of_stream) begin
          for (int i = 0; i < hold_cnt; i++) push_result(0, 0, 0, hold_buf[i], 0);
          push_result(0, 0, 0, it.in_byte, 0);
        end else begin
          hold_buf[hold_cnt] = it.in_byte;
          hold_cnt++;
        end
      end else begin
        hold_cnt = 0;
        if (hold_buf[0] != 8'h49 || hold_buf[1] != 8'h44 || hold_buf[2] != 8'h33 ||
            hold_buf[3] > 8'h04 || hold_buf[4] != 8'h00) begin
          for (int i = 0; i < 9; i++) push_result(0, 0, 0, hold_buf[i], 0);
          push_result(0, 0, 0, it.in_byte, 0);
          phase = PH_PASS;
        end else begin
          flags = hold_buf[5][7] ? FL_UNSYNC : 3'd0;
          tag_left = {hold_buf[6][6:0], hold_buf[7][6:0], hold_buf[8][6:0],
                      it.in_byte[6:0]};
          size_word = 0; frame_id = 0;
          phase = hold_buf[5][6] ? PH_EXT_SIZE : PH_FRAME_ID;
          if (tag_left == 0) phase = PH_PASS;
        end
      end
    end else if (phase == PH_PASS) begin
      push_result(0, 0, 0, it.in_byte, 0);
    end else begin
      deliver = 1;
      tag_left = tag_left - 28'd1;
      if (flags & FL_PENDFF) begin
        flags = flags & ~FL_PENDFF;
        if (it.in_byte == 8'h00) deliver = 0;
      end else if ((flags & FL_UNSYNC) && it.in_byte == 8'hff) begin
        flags = flags | FL_PENDFF;
      end
      if (deliver) parse_tag_byte(it.in_byte);
      if (tag_left == 0) begin
        phase = PH_PASS; flags = 0; field_sel = FLD_NONE; hold_cnt = 0;
      end
    end
    if (it.end_of_stream) clear_parser();
  endtask

  // stimulus building
  task automatic add(logic [7:0] b, logic eos = 1'b0);
    in_item_t it;
    it.in_byte = b; it.end_of_stream = eos;
    byte_q.push_back(it);
  endtask

  task automatic add_header(logic [7:0] ver, logic [7:0] hflags, int unsigned len);
    add(8'h49); add(8'h44); add(8'h33); add(ver); add(8'h00); add(hflags);
    add({1'b0, 7'(len >> 21)}); add({1'b0, 7'(len >> 14)});
    add({1'b0, 7'(len >> 7)}); add({1'b0, 7'(len)});
  endtask

  task automatic add_frame(logic [31:0] id, int unsigned size, logic [7:0] f2,
                           logic [7:0] enc, logic with_ff);
    add(id[31:24]); add(id[23:16]); add(id[15:8]); add(id[7:0]);
    add(8'(size >> 24)); add(8'(size >> 16)); add(8'(size >> 8)); add(8'(size));
    add(8'($urandom)); add(f2);
    for (int i = 0; i < size; i++) begin
      if (i == 0) add(enc);
      else if (with_ff && $urandom_range(0, 4) == 0) add(8'hff);
      else add(8'($urandom));
    end
  endtask

  // one random stream: mostly a well-formed tag, sometimes noise
  task automatic add_random_stream();
    logic [31:0] ids [6];
    logic [31:0] id;
    int unsigned before_n, sz, nfr;
    logic [7:0] hf;
    ids[0] = ID_TALB; ids[1] = ID_TIT2; ids[2] = ID_TPE1; ids[3] = ID_TYER;
    ids[4] = 32'h434f4d4d; ids[5] = $urandom;
    if ($urandom_range(0, 5) == 0) begin
      sz = $urandom_range(1, 14);
      for (int i = 0; i < sz; i++) add(8'($urandom), i == sz - 1);
      return;
    end
    hf = {1'($urandom), 1'($urandom_range(0, 3) == 0), 6'($urandom)};
    before_n = byte_q.size();
    nfr = $urandom_range(1, 3);
    // build body in a temporary tail, then patch length
    add_header(8'($urandom_range(0, 4)), hf, 0);
    if (hf[6]) begin
      sz = $urandom_range(0, 3);
      add(0); add(0); add(0); add(8'(sz));
      for (int i = 0; i < sz; i++) add(8'($urandom));
    end
    for (int f = 0; f < nfr; f++) begin
      id = ids[$urandom_range(0, 5)];
      add_frame(id, $urandom_range(0, 6), $urandom_range(0, 5) == 0 ? 8'h80 : 8'h00,
                8'($urandom_range(0, 2)), hf[7]);
    end
    if ($urandom_range(0, 2) == 0) begin
      for (int i = 0; i < 3; i++) add(8'h00);
    end
    sz = byte_q.size() - before_n - 10;
    // now and then cut the tag short so a field ends without its last marker
    if ($urandom_range(0, 4) == 0 && sz > 2) sz = sz - $urandom_range(1, 2);
    byte_q[before_n + 6].in_byte = {1'b0, 7'(sz >> 21)};
    byte_q[before_n + 7].in_byte = {1'b0, 7'(sz >> 14)};
    byte_q[before_n + 8].in_byte = {1'b0, 7'(sz >> 7)};
    byte_q[before_n + 9].in_byte = {1'b0, 7'(sz)};
    sz = $urandom_range(1, 4);
    for (int i = 0; i < sz; i++) add(8'($urandom), i == sz - 1);
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // directed rows: byte and end marker; results come from the predictor
  typedef struct {
    logic [7:0] b;
    logic       eos;
  } dir_row_t;
  dir_row_t dir_rows [] = '{
    '{8'h00, 1'b1}, '{8'hff, 1'b0}, '{8'h55, 1'b1},
    '{8'h49, 1'b0}, '{8'h44, 1'b0}, '{8'h33, 1'b0}, '{8'h05, 1'b0}, '{8'h00, 1'b0},
    '{8'h00, 1'b0}, '{8'h00, 1'b0}, '{8'h00, 1'b0}, '{8'h00, 1'b0}, '{8'h01, 1'b0},
    '{8'haa, 1'b1},
    '{8'h49, 1'b0}, '{8'h44, 1'b0}, '{8'h33, 1'b0}, '{8'h04, 1'b0}, '{8'h00, 1'b0},
    '{8'hff, 1'b0}, '{8'h00, 1'b0}, '{8'h00, 1'b0}, '{8'h00, 1'b0}, '{8'h00, 1'b0},
    '{8'h7e, 1'b1}
  };

  // sender
  initial begin
    in_item_t it;
    int mode;
    rst_n = 0; in_push = 0; in_data = '0; out_pop = 0;
    clear_parser();
    repeat (10) @(posedge clk);
    @(negedge clk) rst_n = 1;
    foreach (dir_rows[i]) add(dir_rows[i].b, dir_rows[i].eos);
    // tag with extended header, unsync, every field, compressed frame and padding
    add_header(8'h03, 8'hc0, 87);
    add(0); add(0); add(0); add(2); add(8'h11); add(8'h22);
    add_frame(ID_TALB, 3, 8'h00, 8'h01, 1'b0);
    add(ID_TIT2[31:24]); add(ID_TIT2[23:16]); add(ID_TIT2[15:8]); add(ID_TIT2[7:0]);
    add(0); add(0); add(0); add(3); add(0); add(0); add(0); add(8'hff); add(8'h00);
    add(8'h41);
    add_frame(ID_TPE1, 1, 8'h00, 8'h00, 1'b0);
    add_frame(ID_TYER, 0, 8'h00, 8'h00, 1'b0);
    add_frame(ID_TALB, 2, 8'h80, 8'h00, 1'b0);
    add_frame(ID_TYER, 5, 8'h00, 8'h00, 1'b0);
    for (int i = 0; i < 8; i++) add(0);
    add(8'h12); add(8'h34, 1'b1);
    while (byte_q.size() < 140) add_random_stream();
    for (int i = 0; i < byte_q.size(); i++) begin
      mode = (i * 4) / byte_q.size();
      send_idle = (mode == 1 || mode == 3) ? 65 : 0;
      recv_stall = (mode == 2) ? 65 : (mode == 3 ? 13 : 0);
      if (mode == 3) send_idle = 13;
      it = byte_q[i];
      while (send_idle != 0 && $urandom_range(1, 100) <= send_idle) begin
        in_push <= 0;
        @(negedge clk);
      end
      in_push <= 1; in_data <= it;
      @(posedge clk);
      while (in_full) @(posedge clk);
      predict_byte(it);
      @(negedge clk);
    end
    in_push <= 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("id3v2_tag_frame_extractor_top: match");
    else $display("id3v2_tag_frame_extractor_top: mismatch");
    $finish;
  end

  // receiver: change pop at the falling edge, sample at the rising edge
  always @(negedge clk) begin
    if (!rst_n) out_pop <= 0;
    else out_pop <= !(recv_stall != 0 && $urandom_range(1, 100) <= recv_stall);
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result byte %h", out_data.out_byte);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (out_data.out_kind !== want.out_kind) begin
          $error("out_kind: expected %0d, got %0d", want.out_kind, out_data.out_kind);
          errors++;
        end
        if (out_data.field_code !== want.field_code) begin
          $error("field_code: expected %0d, got %0d", want.field_code,
                 out_data.field_code);
          errors++;
        end
        if (out_data.is_unicode !== want.is_unicode) begin
          $error("is_unicode: expected %0d, got %0d", want.is_unicode,
                 out_data.is_unicode);
          errors++;
        end
        if (out_data.out_byte !== want.out_byte) begin
          $error("out_byte: expected %h, got %h", want.out_byte, out_data.out_byte);
          errors++;
        end
        if (out_data.field_last !== want.field_last) begin
          $error("field_last: expected %0d, got %0d", want.field_last,
                 out_data.field_last);
          errors++;
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("id3v2_tag_frame_extractor_top: mismatch");
    $finish;
  end

endmodule
